@@ sv/exptok_pkg.sv @@
package exptok_pkg;

   localparam int MAX_LINE = 4096;

   localparam int COL_W   = 13;
   localparam int VALUE_W = 48;
   localparam int FRAC_W  = 6;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
   localparam logic [FRAC_W-1:0]  FRAC_MAX  = '1;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   localparam logic [3:0] K_IDENT  = 4'd0;
   localparam logic [3:0] K_NUMBER = 4'd1;
   localparam logic [3:0] K_STRING = 4'd2;
   localparam logic [3:0] K_PLUS   = 4'd3;
   localparam logic [3:0] K_MINUS  = 4'd4;
   localparam logic [3:0] K_STAR   = 4'd5;
   localparam logic [3:0] K_SLASH  = 4'd6;
   localparam logic [3:0] K_SEMI   = 4'd7;
   localparam logic [3:0] K_LPAREN = 4'd8;
   localparam logic [3:0] K_RPAREN = 4'd9;
   localparam logic [3:0] K_ASSIGN = 4'd10;
   localparam logic [3:0] K_EQEQ   = 4'd11;
   localparam logic [3:0] K_NOTEQ  = 4'd12;
   localparam logic [3:0] K_NOT    = 4'd13;
   localparam logic [3:0] K_EOF    = 4'd14;
   localparam logic [3:0] K_ERROR  = 4'd15;

   localparam logic [1:0] E_NONE     = 2'd0;
   localparam logic [1:0] E_NO_FRAC  = 2'd1;
   localparam logic [1:0] E_OPEN_STR = 2'd2;

   typedef enum logic [3:0] {
      M_IDLE,
      M_IDENT,
      M_INT,
      M_POINT,
      M_FRAC,
      M_STRING,
      M_EQ,
      M_BANG,
      M_DISCARD
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic [COL_W-1:0]   position;
      logic [COL_W-1:0]   length;
      logic [VALUE_W-1:0] number_value;
      logic [FRAC_W-1:0]  fraction_digits;
      logic               overflow;
      logic [1:0]         error_code;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic rsp_type make_rsp(input logic [3:0] kind,
                                        input logic [COL_W-1:0] pos,
                                        input logic [COL_W-1:0] len,
                                        input logic [VALUE_W-1:0] val,
                                        input logic [FRAC_W-1:0] frac,
                                        input logic ovf,
                                        input logic [1:0] err);
      rsp_type r;
      r.kind            = kind;
      r.position        = pos;
      r.length          = len;
      r.number_value    = val;
      r.fraction_digits = frac;
      r.overflow        = ovf;
      r.error_code      = err;
      r.last            = 1'b0;
      return r;
   endfunction

endpackage

@@ sv/exptok_fifo.sv @@
module exptok_fifo (
   input  logic                clock,
   input  logic                reset,
   input  exptok_pkg::push_type push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output exptok_pkg::rsp_type rsp_word
);

   exptok_pkg::rsp_type ent_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] wr_next;

   assign room      = (cnt_ff <= 3'd2);
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_word  = ent_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ff + 2'd1;

   always_comb begin
      wr_in  = wr_ff + push.count;
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         ent_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         ent_ff[wr_next] <= push.second;
      end
   end

endmodule

@@ sv/expression_tokenizer_core.sv @@
// Channel | Ports                          | Moves
// req     | req_valid req_ready req_word   | one character or the line terminator
// rsp     | rsp_valid rsp_ready rsp_word   | one token word, last marks an item's final one
//
// An accepted item updates the scan state in the same cycle and pushes zero,
// one or two token words into a four-entry output queue.
// One item per cycle; req_ready drops while fewer than two queue slots are free.
// An item's first token word can reach rsp in the cycle after the item is accepted.
// Reset clears the scan mode, the column and the queue.
module expression_tokenizer_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  exptok_pkg::req_type req_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output exptok_pkg::rsp_type rsp_word
);

   localparam int CW = exptok_pkg::COL_W;
   localparam int VW = exptok_pkg::VALUE_W;
   localparam int FW = exptok_pkg::FRAC_W;

   exptok_pkg::mode_type mode_ff, mode_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] start_ff, start_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [FW-1:0] frac_ff, frac_in;
   logic          sat_ff, sat_in;

   exptok_pkg::push_type push;
   exptok_pkg::rsp_type  tok_a, tok_b;
   logic                 a_vld, b_vld;
   logic                 go_idle;
   logic                 room;
   logic                 take;

   logic [7:0]    c;
   logic          fin;
   logic [VW-1:0] d;
   logic [VW+3:0] acc_dig;
   logic [VW-1:0] acc_step;
   logic          dig_sat;
   logic [FW-1:0] frac_step;
   logic          frac_sat;
   logic [CW-1:0] col_inc;
   logic          dig;

   assign req_ready = room;
   assign take      = req_valid && room;
   assign c         = req_word.ch;
   assign fin       = req_word.line_end;
   assign dig       = exptok_pkg::is_digit(c);
   assign col_inc   = col_ff + CW'(1);

   assign d         = VW'(c - exptok_pkg::CH_ZERO);
   assign acc_dig   = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {4'b0000, d};
   assign dig_sat   = (acc_dig[VW+3:VW] != 4'd0);
   assign acc_step  = dig_sat ? exptok_pkg::VALUE_MAX : acc_dig[VW-1:0];
   assign frac_sat  = (frac_ff == exptok_pkg::FRAC_MAX);
   assign frac_step = frac_sat ? frac_ff : frac_ff + FW'(1);

   always_comb begin
      mode_in  = mode_ff;
      col_in   = col_ff;
      start_in = start_ff;
      acc_in   = acc_ff;
      frac_in  = frac_ff;
      sat_in   = sat_ff;
      tok_a    = '0;
      tok_b    = '0;
      a_vld    = 1'b0;
      b_vld    = 1'b0;
      go_idle  = 1'b0;

      if (mode_ff == exptok_pkg::M_DISCARD) begin
         if (fin) begin
            mode_in = exptok_pkg::M_IDLE;
            col_in  = '0;
         end
      end else if (!fin && col_ff >= CW'(exptok_pkg::MAX_LINE)) begin
         mode_in = mode_ff;
      end else begin
         case (mode_ff)
            exptok_pkg::M_EQ, exptok_pkg::M_BANG: begin
               a_vld   = 1'b1;
               mode_in = exptok_pkg::M_IDLE;
               if (!fin && c == exptok_pkg::CH_EQUAL) begin
                  tok_a = exptok_pkg::make_rsp(
                     (mode_ff == exptok_pkg::M_EQ) ? exptok_pkg::K_EQEQ : exptok_pkg::K_NOTEQ,
                     start_ff + CW'(1), '0, '0, '0, 1'b0, exptok_pkg::E_NONE);
                  col_in = col_inc;
               end else begin
                  tok_a = exptok_pkg::make_rsp(
                     (mode_ff == exptok_pkg::M_EQ) ? exptok_pkg::K_ASSIGN : exptok_pkg::K_NOT,
                     start_ff + CW'(1), '0, '0, '0, 1'b0, exptok_pkg::E_NONE);
                  go_idle = 1'b1;
               end
            end
            exptok_pkg::M_IDENT: begin
               if (!fin && (exptok_pkg::is_alpha(c) || dig)) begin
                  col_in = col_inc;
               end else begin
                  a_vld   = 1'b1;
                  tok_a   = exptok_pkg::make_rsp(exptok_pkg::K_IDENT, start_ff + CW'(1),
                               col_ff - start_ff, '0, '0, 1'b0, exptok_pkg::E_NONE);
                  mode_in = exptok_pkg::M_IDLE;
                  go_idle = 1'b1;
               end
            end
            exptok_pkg::M_INT, exptok_pkg::M_FRAC: begin
               if (!fin && dig) begin
                  acc_in = acc_step;
                  col_in = col_inc;
                  if (mode_ff == exptok_pkg::M_FRAC) begin
                     frac_in = frac_step;
                     sat_in  = sat_ff | dig_sat | frac_sat;
                  end else begin
                     sat_in  = sat_ff | dig_sat;
                  end
               end else if (!fin && mode_ff == exptok_pkg::M_INT
                            && c == exptok_pkg::CH_POINT) begin
                  mode_in = exptok_pkg::M_POINT;
                  col_in  = col_inc;
               end else begin
                  a_vld   = 1'b1;
                  tok_a   = exptok_pkg::make_rsp(exptok_pkg::K_NUMBER, start_ff + CW'(1),
                               col_ff - start_ff, acc_ff, frac_ff, sat_ff,
                               exptok_pkg::E_NONE);
                  mode_in = exptok_pkg::M_IDLE;
                  go_idle = 1'b1;
               end
            end
            exptok_pkg::M_POINT: begin
               if (!fin && dig) begin
                  acc_in  = acc_step;
                  frac_in = frac_step;
                  sat_in  = sat_ff | dig_sat | frac_sat;
                  mode_in = exptok_pkg::M_FRAC;
                  col_in  = col_inc;
               end else begin
                  a_vld = 1'b1;
                  tok_a = exptok_pkg::make_rsp(exptok_pkg::K_ERROR, col_ff, '0, '0, '0,
                             1'b0, exptok_pkg::E_NO_FRAC);
                  if (fin) begin
                     mode_in = exptok_pkg::M_IDLE;
                     col_in  = '0;
                  end else begin
                     mode_in = exptok_pkg::M_DISCARD;
                  end
               end
            end
            exptok_pkg::M_STRING: begin
               if (fin || c inside {exptok_pkg::CH_NUL, exptok_pkg::CH_LF}) begin
                  a_vld = 1'b1;
                  tok_a = exptok_pkg::make_rsp(exptok_pkg::K_ERROR, col_ff, '0, '0, '0,
                             1'b0, exptok_pkg::E_OPEN_STR);
                  if (fin) begin
                     mode_in = exptok_pkg::M_IDLE;
                     col_in  = '0;
                  end else begin
                     mode_in = exptok_pkg::M_DISCARD;
                  end
               end else begin
                  if (c == exptok_pkg::CH_QUOTE) begin
                     a_vld   = 1'b1;
                     tok_a   = exptok_pkg::make_rsp(exptok_pkg::K_STRING, start_ff + CW'(1),
                                  col_ff - start_ff - CW'(1), '0, '0, 1'b0,
                                  exptok_pkg::E_NONE);
                     mode_in = exptok_pkg::M_IDLE;
                  end
                  col_in = col_inc;
               end
            end
            default: begin
               mode_in = exptok_pkg::M_IDLE;
               go_idle = 1'b1;
            end
         endcase

         if (go_idle) begin
            if (fin) begin
               b_vld  = 1'b1;
               tok_b  = exptok_pkg::make_rsp(exptok_pkg::K_EOF, col_inc, '0, '0, '0, 1'b0,
                           exptok_pkg::E_NONE);
               col_in = '0;
            end else begin
               col_in = col_inc;
               tok_b  = exptok_pkg::make_rsp(exptok_pkg::K_PLUS, col_inc, '0, '0, '0, 1'b0,
                           exptok_pkg::E_NONE);
               case (c)
                  exptok_pkg::CH_PLUS: begin
                     b_vld = 1'b1;
                  end
                  exptok_pkg::CH_MINUS: begin
                     b_vld      = 1'b1;
                     tok_b.kind = exptok_pkg::K_MINUS;
                  end
                  exptok_pkg::CH_STAR: begin
                     b_vld      = 1'b1;
                     tok_b.kind = exptok_pkg::K_STAR;
                  end
                  exptok_pkg::CH_SLASH: begin
                     b_vld      = 1'b1;
                     tok_b.kind = exptok_pkg::K_SLASH;
                  end
                  exptok_pkg::CH_SEMI: begin
                     b_vld      = 1'b1;
                     tok_b.kind = exptok_pkg::K_SEMI;
                  end
                  exptok_pkg::CH_LPAREN: begin
                     b_vld      = 1'b1;
                     tok_b.kind = exptok_pkg::K_LPAREN;
                  end
                  exptok_pkg::CH_RPAREN: begin
                     b_vld      = 1'b1;
                     tok_b.kind = exptok_pkg::K_RPAREN;
                  end
                  exptok_pkg::CH_EQUAL: begin
                     start_in = col_ff;
                     mode_in  = exptok_pkg::M_EQ;
                  end
                  exptok_pkg::CH_BANG: begin
                     start_in = col_ff;
                     mode_in  = exptok_pkg::M_BANG;
                  end
                  exptok_pkg::CH_QUOTE: begin
                     start_in = col_ff;
                     mode_in  = exptok_pkg::M_STRING;
                  end
                  default: begin
                     if (dig) begin
                        start_in = col_ff;
                        acc_in   = d;
                        frac_in  = '0;
                        sat_in   = 1'b0;
                        mode_in  = exptok_pkg::M_INT;
                     end else if (exptok_pkg::is_alpha(c) || c == exptok_pkg::CH_UNDER) begin
                        start_in = col_ff;
                        mode_in  = exptok_pkg::M_IDENT;
                     end
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      push = '0;
      if (take) begin
         if (a_vld) begin
            push.first       = tok_a;
            push.second      = tok_b;
            push.count       = b_vld ? 2'd2 : 2'd1;
            push.first.last  = !b_vld;
            push.second.last = 1'b1;
         end else if (b_vld) begin
            push.first      = tok_b;
            push.count      = 2'd1;
            push.first.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= exptok_pkg::M_IDLE;
         col_ff   <= '0;
         start_ff <= '0;
         acc_ff   <= '0;
         frac_ff  <= '0;
         sat_ff   <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         col_ff   <= col_in;
         start_ff <= start_in;
         acc_ff   <= acc_in;
         frac_ff  <= frac_in;
         sat_ff   <= sat_in;
      end
   end

   exptok_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
